### hdl/twlw_pkg.sv
// shared types, codes and defaults for the text window line writer
package twlw_pkg;

	localparam int WINDOW_COUNT_DEF = 4;
	localparam int LINE_COLUMNS_DEF = 32;
	localparam int WINDOW_ROWS_DEF  = 24;
	localparam int TAB_WIDTH_DEF    = 4;

	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_SPACE   = 8'd32;

	typedef enum logic [1:0] {
		EV_STORE  = 2'd0,
		EV_SCROLL = 2'd1,
		EV_LINE   = 2'd2
	} event_kind_t;

	// program steps of the sequencer
	typedef enum logic [3:0] {
		UPC_IDLE     = 4'd0,
		UPC_DISPATCH = 4'd1,
		UPC_SPLIT    = 4'd2,
		UPC_TAB      = 4'd3,
		UPC_SORT     = 4'd4,
		UPC_CHAR     = 4'd5,
		UPC_CHECK    = 4'd6,
		UPC_CLOSE    = 4'd7,
		UPC_SCROLL   = 4'd8,
		UPC_LINE     = 4'd9,
		UPC_WRITE    = 4'd10
	} upc_t;

	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_BEAT     = 3'd1,
		COND_BAD_WIN  = 3'd2,
		COND_TAB      = 3'd3,
		COND_NEWLINE  = 3'd4,
		COND_TAB_MORE = 3'd5,
		COND_COL_FULL = 3'd6,
		COND_ROW_FULL = 3'd7
	} cond_t;

	typedef enum logic [1:0] {
		COL_KEEP  = 2'd0,
		COL_INC   = 2'd1,
		COL_CLEAR = 2'd2
	} col_op_t;

	typedef enum logic [1:0] {
		ROW_KEEP = 2'd0,
		ROW_TOP  = 2'd1,
		ROW_INC  = 2'd2
	} row_op_t;

	typedef enum logic [1:0] {
		LAST_NEVER  = 2'd0,
		LAST_ALWAYS = 2'd1,
		LAST_TAB    = 2'd2,
		LAST_CHAR   = 2'd3
	} last_mode_t;

	// one control word of the program
	typedef struct packed {
		logic        accept;
		logic        emit;
		event_kind_t kind;
		logic        space;
		col_op_t     col_op;
		row_op_t     row_op;
		last_mode_t  last_mode;
		logic        wb;
		cond_t       cond;
		upc_t        jump;
		upc_t        next;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic go;
		logic beat;
		logic bad_win;
		logic is_tab;
		logic is_newline;
		logic tab_more;
		logic col_full;
		logic row_full;
	} flags_t;

endpackage

### hdl/twlw_if.sv
// channel interfaces: character input and event output
interface twlw_in_if import twlw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic [1:0] window;

	modport source(output valid, char_code, window, input ready);
	modport sink(input valid, char_code, window, output ready);
endinterface

interface twlw_out_if import twlw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [1:0] window_out;
	logic [4:0] column;
	logic [7:0] stored_code;
	logic [4:0] row;
	logic [5:0] line_length;
	logic       last;

	modport source(output valid, event_kind, window_out, column, stored_code, row,
		line_length, last, input ready);
	modport sink(input valid, event_kind, window_out, column, stored_code, row,
		line_length, last, output ready);
endinterface

### hdl/twlw_ucode_rom.sv
// control store: the per-character program, one control word per step
module twlw_ucode_rom import twlw_pkg::*; (
	input  upc_t  upc,
	output ctrl_t ctrl
);

	always_comb begin
		ctrl = '{accept: 1'b0, emit: 1'b0, kind: EV_STORE, space: 1'b0,
			col_op: COL_KEEP, row_op: ROW_KEEP, last_mode: LAST_NEVER, wb: 1'b0,
			cond: COND_ALWAYS, jump: UPC_IDLE, next: UPC_IDLE};
		case (upc)
			UPC_IDLE: begin
				ctrl.accept = 1'b1;
				ctrl.cond   = COND_BEAT;
				ctrl.jump   = UPC_DISPATCH;
				ctrl.next   = UPC_IDLE;
			end
			UPC_DISPATCH: begin
				ctrl.cond = COND_BAD_WIN;
				ctrl.jump = UPC_IDLE;
				ctrl.next = UPC_SPLIT;
			end
			UPC_SPLIT: begin
				ctrl.cond = COND_TAB;
				ctrl.jump = UPC_TAB;
				ctrl.next = UPC_SORT;
			end
			UPC_TAB: begin
				ctrl.emit      = 1'b1;
				ctrl.kind      = EV_STORE;
				ctrl.space     = 1'b1;
				ctrl.col_op    = COL_INC;
				ctrl.last_mode = LAST_TAB;
				ctrl.cond      = COND_TAB_MORE;
				ctrl.jump      = UPC_TAB;
				ctrl.next      = UPC_CHECK;
			end
			UPC_SORT: begin
				ctrl.cond = COND_NEWLINE;
				ctrl.jump = UPC_CLOSE;
				ctrl.next = UPC_CHAR;
			end
			UPC_CHAR: begin
				ctrl.emit      = 1'b1;
				ctrl.kind      = EV_STORE;
				ctrl.col_op    = COL_INC;
				ctrl.last_mode = LAST_CHAR;
				ctrl.next      = UPC_CHECK;
				ctrl.jump      = UPC_CHECK;
			end
			UPC_CHECK: begin
				ctrl.cond = COND_COL_FULL;
				ctrl.jump = UPC_CLOSE;
				ctrl.next = UPC_WRITE;
			end
			UPC_CLOSE: begin
				ctrl.cond = COND_ROW_FULL;
				ctrl.jump = UPC_SCROLL;
				ctrl.next = UPC_LINE;
			end
			UPC_SCROLL: begin
				ctrl.emit      = 1'b1;
				ctrl.kind      = EV_SCROLL;
				ctrl.row_op    = ROW_TOP;
				ctrl.last_mode = LAST_NEVER;
				ctrl.jump      = UPC_LINE;
				ctrl.next      = UPC_LINE;
			end
			UPC_LINE: begin
				ctrl.emit      = 1'b1;
				ctrl.kind      = EV_LINE;
				ctrl.col_op    = COL_CLEAR;
				ctrl.row_op    = ROW_INC;
				ctrl.last_mode = LAST_ALWAYS;
				ctrl.jump      = UPC_WRITE;
				ctrl.next      = UPC_WRITE;
			end
			UPC_WRITE: begin
				ctrl.wb   = 1'b1;
				ctrl.jump = UPC_IDLE;
				ctrl.next = UPC_IDLE;
			end
			default: begin
				ctrl.jump = UPC_IDLE;
				ctrl.next = UPC_IDLE;
			end
		endcase
	end

endmodule

### hdl/twlw_sequencer.sv
// step counter with conditional jumps
module twlw_sequencer import twlw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  ctrl_t  ctrl,
	input  flags_t flags,
	output upc_t   upc
);

	upc_t upc_q;
	logic taken;

	always_comb begin
		case (ctrl.cond)
			COND_ALWAYS:   taken = 1'b1;
			COND_BEAT:     taken = flags.beat;
			COND_BAD_WIN:  taken = flags.bad_win;
			COND_TAB:      taken = flags.is_tab;
			COND_NEWLINE:  taken = flags.is_newline;
			COND_TAB_MORE: taken = flags.tab_more;
			COND_COL_FULL: taken = flags.col_full;
			COND_ROW_FULL: taken = flags.row_full;
			default:       taken = 1'b0;
		endcase
	end

	// hold the step while its event waits for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else if (flags.go) begin
			upc_q <= taken ? ctrl.jump : ctrl.next;
		end
	end

	assign upc = upc_q;

endmodule

### hdl/twlw_datapath.sv
// window counters, working registers, event formatting and output register
module twlw_datapath import twlw_pkg::*; #(
	parameter int WINDOW_COUNT = WINDOW_COUNT_DEF,
	parameter int LINE_COLUMNS = LINE_COLUMNS_DEF,
	parameter int WINDOW_ROWS  = WINDOW_ROWS_DEF,
	parameter int TAB_WIDTH    = TAB_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ctrl_t           ctrl,
	output flags_t          flags,
	twlw_in_if.sink         char_in,
	twlw_out_if.source      event_out
);

	localparam int CW = $clog2(LINE_COLUMNS + 1);
	localparam int RW = $clog2(WINDOW_ROWS + 1);
	localparam int PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int IW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

	logic [CW-1:0] col_mem_q   [WINDOW_COUNT];
	logic [RW-1:0] row_mem_q   [WINDOW_COUNT];
	logic [PW-1:0] phase_mem_q [WINDOW_COUNT];

	logic [7:0]    code_q;
	logic [1:0]    win_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] phase_q;

	logic          ev_valid_q;
	logic [1:0]    ev_kind_q;
	logic [1:0]    ev_win_q;
	logic [4:0]    ev_col_q;
	logic [7:0]    ev_code_q;
	logic [4:0]    ev_row_q;
	logic [5:0]    ev_len_q;
	logic          ev_last_q;

	logic [31:0]   in_win_w;
	logic [31:0]   win_w;
	logic [31:0]   col_w;
	logic [31:0]   row_w;
	logic [IW-1:0] in_idx;
	logic [IW-1:0] idx;
	logic          in_ok;
	logic          win_ok;
	logic          beat;
	logic          go;
	logic          fire;
	logic [CW-1:0] col_inc;
	logic [PW-1:0] phase_inc;
	logic          inc_open;
	logic          tab_more;
	logic          last;

	assign in_win_w = 32'(char_in.window);
	assign win_w    = 32'(win_q);
	assign in_idx   = in_win_w[IW-1:0];
	assign idx      = win_w[IW-1:0];
	assign in_ok    = in_win_w < 32'(WINDOW_COUNT);
	assign win_ok   = win_w < 32'(WINDOW_COUNT);

	assign char_in.ready = ctrl.accept;
	assign beat          = char_in.valid && ctrl.accept;
	assign go            = !ctrl.emit || !ev_valid_q || event_out.ready;
	assign fire          = ctrl.emit && go;

	// phase tracks column modulo tab width
	assign col_inc   = col_q + CW'(1);
	assign phase_inc = (phase_q == PW'(TAB_WIDTH - 1)) ? '0 : phase_q + PW'(1);
	assign inc_open  = col_inc < CW'(LINE_COLUMNS);
	assign tab_more  = inc_open && (phase_inc != '0);

	always_comb begin
		case (ctrl.last_mode)
			LAST_NEVER:  last = 1'b0;
			LAST_ALWAYS: last = 1'b1;
			LAST_TAB:    last = inc_open && !tab_more;
			LAST_CHAR:   last = inc_open;
			default:     last = 1'b0;
		endcase
	end

	assign flags = '{go: go, beat: beat, bad_win: !win_ok,
		is_tab: code_q == CODE_TAB, is_newline: code_q == CODE_NEWLINE,
		tab_more: tab_more, col_full: col_q >= CW'(LINE_COLUMNS),
		row_full: row_q >= RW'(WINDOW_ROWS)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_COUNT; i++) begin
				col_mem_q[i]   <= '0;
				row_mem_q[i]   <= '0;
				phase_mem_q[i] <= '0;
			end
		end else if (ctrl.wb && win_ok) begin
			col_mem_q[idx]   <= col_q;
			row_mem_q[idx]   <= row_q;
			phase_mem_q[idx] <= phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q  <= '0;
			win_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (beat) begin
			code_q <= char_in.char_code;
			win_q  <= char_in.window;
			if (in_ok) begin
				col_q   <= col_mem_q[in_idx];
				row_q   <= row_mem_q[in_idx];
				phase_q <= phase_mem_q[in_idx];
			end else begin
				col_q   <= '0;
				row_q   <= '0;
				phase_q <= '0;
			end
		end else if (go) begin
			case (ctrl.col_op)
				COL_INC: begin
					col_q   <= col_inc;
					phase_q <= phase_inc;
				end
				COL_CLEAR: begin
					col_q   <= '0;
					phase_q <= '0;
				end
				default: begin
					col_q   <= col_q;
					phase_q <= phase_q;
				end
			endcase
			case (ctrl.row_op)
				ROW_TOP:  row_q <= RW'(WINDOW_ROWS - 1);
				ROW_INC:  row_q <= row_q + RW'(1);
				default:  row_q <= row_q;
			endcase
		end
	end

	assign col_w = 32'(col_q);
	assign row_w = 32'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (fire) begin
			ev_valid_q <= 1'b1;
		end else if (event_out.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_kind_q <= ctrl.kind;
			ev_win_q  <= win_q;
			ev_last_q <= last;
			ev_col_q  <= (ctrl.kind == EV_STORE) ? col_w[4:0] : '0;
			ev_code_q <= (ctrl.kind == EV_STORE) ? (ctrl.space ? CODE_SPACE : code_q) : '0;
			ev_row_q  <= (ctrl.kind == EV_LINE) ? row_w[4:0] : '0;
			ev_len_q  <= (ctrl.kind == EV_LINE) ? col_w[5:0] : '0;
		end
	end

	assign event_out.valid       = ev_valid_q;
	assign event_out.event_kind  = ev_kind_q;
	assign event_out.window_out  = ev_win_q;
	assign event_out.column      = ev_col_q;
	assign event_out.stored_code = ev_code_q;
	assign event_out.row         = ev_row_q;
	assign event_out.line_length = ev_len_q;
	assign event_out.last        = ev_last_q;

endmodule

### hdl/text_window_line_writer.sv
// top level of the text window line writer
//
// char_in takes one character beat (char_code, window); 9 expands to spaces up to
// the next tab stop, 10 closes the line, every other code is stored as given.
// event_out gives one beat per event: store, scroll or line complete, with last
// set on the final event that a character causes. a window number at or above
// WINDOW_COUNT is dropped without events.
// a short program in the control store steps through each character, one step a
// cycle while event_out is not stalled, and every event step fills the output
// register. a character in a valid window runs dispatch and split, then the tab
// steps for a tab, or sort and then char for a printable code; a newline or a
// full line runs close, scroll when the rows are full, and line; write stores
// the counters back. char_in is ready only in the idle step, so the next
// character is taken only once the program for the last one has ended.
// while event_out is stalled, a step that has an event to give holds and
// char_in stays not ready until the item is done.
// reset clears every window's column and row count to zero and empties the
// output register; the block takes a character in the first cycle after reset.
module text_window_line_writer import twlw_pkg::*; #(
	parameter int WINDOW_COUNT = WINDOW_COUNT_DEF,
	parameter int LINE_COLUMNS = LINE_COLUMNS_DEF,
	parameter int WINDOW_ROWS  = WINDOW_ROWS_DEF,
	parameter int TAB_WIDTH    = TAB_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	twlw_in_if.sink    char_in,
	twlw_out_if.source event_out
);

	upc_t   upc;
	ctrl_t  ctrl;
	flags_t flags;

	twlw_ucode_rom u_rom (
		.upc  (upc),
		.ctrl (ctrl)
	);

	twlw_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.upc    (upc)
	);

	twlw_datapath #(
		.WINDOW_COUNT (WINDOW_COUNT),
		.LINE_COLUMNS (LINE_COLUMNS),
		.WINDOW_ROWS  (WINDOW_ROWS),
		.TAB_WIDTH    (TAB_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.flags     (flags),
		.char_in   (char_in),
		.event_out (event_out)
	);

endmodule
